// ===== rtl/id3_pkg.sv =====
// ----------------------------------------------------------------------------
// id3_pkg
// Shared types and constants for the tag header parser and unsync filter.
// ----------------------------------------------------------------------------
package id3_pkg;

   localparam int SIZE_W     = 28;
   localparam int HDR_IDX_W  = 4;
   localparam int QUEUE_CNT_W = 2;

   localparam logic [HDR_IDX_W-1:0] HDR_IDX_MARK0  = 4'd0;
   localparam logic [HDR_IDX_W-1:0] HDR_IDX_MARK1  = 4'd1;
   localparam logic [HDR_IDX_W-1:0] HDR_IDX_MARK2  = 4'd2;
   localparam logic [HDR_IDX_W-1:0] HDR_IDX_MAJOR  = 4'd3;
   localparam logic [HDR_IDX_W-1:0] HDR_IDX_REV    = 4'd4;
   localparam logic [HDR_IDX_W-1:0] HDR_IDX_FLAGS  = 4'd5;
   localparam logic [HDR_IDX_W-1:0] HDR_IDX_LAST   = 4'd9;

   localparam logic [7:0] MARK_CHAR0  = 8'h49;  // 'I'
   localparam logic [7:0] MARK_CHAR1  = 8'h44;  // 'D'
   localparam logic [7:0] MARK_CHAR2  = 8'h33;  // '3'
   localparam logic [7:0] BYTE_FF     = 8'hFF;
   localparam logic [7:0] BYTE_ZERO   = 8'h00;
   localparam logic [7:0] MAJOR_MIN   = 8'd2;
   localparam logic [7:0] MAJOR_MAX   = 8'd4;
   localparam logic [7:0] MAJOR_UNSYNC = 8'd3;
   localparam int         UNSYNC_BIT  = 7;

   localparam logic [QUEUE_CNT_W-1:0] QUEUE_DEPTH = 2'd2;

   typedef enum logic [1:0] {
      KIND_BODY   = 2'd0,
      KIND_ACCEPT = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef struct packed {
      logic [SIZE_W-1:0] tag_size;
      logic [7:0]        tag_flags;
      logic [7:0]        revision;
      logic [7:0]        major_version;
      logic              last_of_tag;
      logic              byte_present;
      logic [7:0]        body_byte;
      kind_type          report_kind;
   } result_type;

   typedef struct packed {
      logic                   full;
      logic [QUEUE_CNT_W-1:0] count;
   } queue_status_type;

endpackage

// ===== rtl/id3_front.sv =====
// ----------------------------------------------------------------------------
// id3_front
// Parses header bytes, tracks the body count and unsync history, and
// classifies each accepted byte into zero or one result.
// ----------------------------------------------------------------------------
module id3_front
   import id3_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_fire,
   input  logic [7:0] data_byte,
   output logic       res_valid,
   output result_type res
);

   logic [HDR_IDX_W-1:0] header_index_ff, header_index_in;
   logic                 mark_ok_ff, mark_ok_in;
   logic [7:0]           major_ff, major_in;
   logic [7:0]           revision_ff, revision_in;
   logic [7:0]           flags_ff, flags_in;
   logic [SIZE_W-1:0]    size_accum_ff, size_accum_in;
   logic [SIZE_W-1:0]    bytes_left_ff, bytes_left_in;
   logic                 in_body_ff, in_body_in;
   logic                 strip_ff, strip_in;
   logic                 prev_ff_ff, prev_ff_in;

   logic                 drop;
   logic                 hdr_ok;
   logic [SIZE_W-1:0]    left_dec;

   always_comb begin
      header_index_in = header_index_ff;
      mark_ok_in      = mark_ok_ff;
      major_in        = major_ff;
      revision_in     = revision_ff;
      flags_in        = flags_ff;
      size_accum_in   = size_accum_ff;
      bytes_left_in   = bytes_left_ff;
      in_body_in      = in_body_ff;
      strip_in        = strip_ff;
      prev_ff_in      = prev_ff_ff;
      res_valid       = 1'b0;
      res             = '0;
      res.report_kind = KIND_BODY;
      drop            = 1'b0;
      hdr_ok          = 1'b0;
      left_dec        = bytes_left_ff - 1'b1;

      if (in_body_ff) begin
         drop               = strip_ff && prev_ff_ff && (data_byte == BYTE_ZERO);
         res_valid          = 1'b1;
         res.report_kind    = KIND_BODY;
         res.body_byte      = drop ? BYTE_ZERO : data_byte;
         res.byte_present   = !drop;
         prev_ff_in         = (data_byte == BYTE_FF);
         bytes_left_in      = left_dec;
         if (left_dec == '0) begin
            res.last_of_tag = 1'b1;
            in_body_in      = 1'b0;
            strip_in        = 1'b0;
            prev_ff_in      = 1'b0;
            header_index_in = '0;
            mark_ok_in      = 1'b1;
            major_in        = '0;
            revision_in     = '0;
            flags_in        = '0;
            size_accum_in   = '0;
         end
      end else begin
         unique case (header_index_ff)
            HDR_IDX_MARK0: if (data_byte != MARK_CHAR0) mark_ok_in = 1'b0;
            HDR_IDX_MARK1: if (data_byte != MARK_CHAR1) mark_ok_in = 1'b0;
            HDR_IDX_MARK2: if (data_byte != MARK_CHAR2) mark_ok_in = 1'b0;
            HDR_IDX_MAJOR: major_in    = data_byte;
            HDR_IDX_REV:   revision_in = data_byte;
            HDR_IDX_FLAGS: flags_in    = data_byte;
            // sync-safe size: seven bits per byte, top bit ignored
            default:       size_accum_in = {size_accum_ff[SIZE_W-8:0], data_byte[6:0]};
         endcase

         if (header_index_ff != HDR_IDX_LAST) begin
            header_index_in = header_index_ff + 1'b1;
         end else begin
            hdr_ok = mark_ok_in && (size_accum_in != '0) &&
                     (major_in >= MAJOR_MIN) && (major_in <= MAJOR_MAX);
            res_valid         = 1'b1;
            res.report_kind   = hdr_ok ? KIND_ACCEPT : KIND_REJECT;
            res.major_version = major_in;
            res.revision      = revision_in;
            res.tag_flags     = flags_in;
            res.tag_size      = size_accum_in;
            if (hdr_ok) begin
               in_body_in    = 1'b1;
               bytes_left_in = size_accum_in;
               strip_in      = (major_in == MAJOR_UNSYNC) && flags_in[UNSYNC_BIT];
               prev_ff_in    = 1'b0;
            end
            header_index_in = '0;
            mark_ok_in      = 1'b1;
            major_in        = '0;
            revision_in     = '0;
            flags_in        = '0;
            size_accum_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_index_ff <= '0;
         mark_ok_ff      <= 1'b1;
         major_ff        <= '0;
         revision_ff     <= '0;
         flags_ff        <= '0;
         size_accum_ff   <= '0;
         bytes_left_ff   <= '0;
         in_body_ff      <= 1'b0;
         strip_ff        <= 1'b0;
         prev_ff_ff      <= 1'b0;
      end else if (byte_fire) begin
         header_index_ff <= header_index_in;
         mark_ok_ff      <= mark_ok_in;
         major_ff        <= major_in;
         revision_ff     <= revision_in;
         flags_ff        <= flags_in;
         size_accum_ff   <= size_accum_in;
         bytes_left_ff   <= bytes_left_in;
         in_body_ff      <= in_body_in;
         strip_ff        <= strip_in;
         prev_ff_ff      <= prev_ff_in;
      end
   end

endmodule

// ===== rtl/id3_queue.sv =====
// ----------------------------------------------------------------------------
// id3_queue
// Two-entry result queue; the head entry drives the output channel directly.
// ----------------------------------------------------------------------------
module id3_queue
   import id3_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  result_type       push_data,
   input  logic             pop,
   output logic             head_valid,
   output result_type       head_data,
   output queue_status_type status
);

   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   result_type             slot0_ff, slot0_in;
   result_type             slot1_ff, slot1_in;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == '0) slot0_in = push_data;
            else                slot1_in = push_data;
            count_in = count_ff + 1'b1;
         end
         2'b01: begin
            slot0_in = slot1_ff;
            count_in = count_ff - 1'b1;
         end
         2'b11: begin
            // one in, one out: count holds
            if (count_ff == QUEUE_DEPTH) begin
               slot0_in = slot1_ff;
               slot1_in = push_data;
            end else begin
               slot0_in = push_data;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign head_valid   = (count_ff != '0);
   assign head_data    = slot0_ff;
   assign status.count = count_ff;
   assign status.full  = (count_ff == QUEUE_DEPTH);

endmodule

// ===== rtl/id3v2_header_and_unsync_filter.sv =====
// ----------------------------------------------------------------------------
// id3v2_header_and_unsync_filter
// Tag header parser and whole-tag unsynchronisation filter on byte streams.
// ----------------------------------------------------------------------------
// One tag byte is taken per cycle, back to back; req_tready stays high while
// the two-entry result queue has room, so with rsp_tready held high the block
// runs at one byte per clock. A byte's result is registered into the queue and
// is offered once it sits at the queue head. Header bytes one to nine give no
// result; the tenth gives an accept or reject report with the decoded header.
// Every body byte gives one result, with byte_present low where an unsync
// zero was removed, and tlast marks the final body byte of the tag.
module id3v2_header_and_unsync_filter
   import id3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [7:0] body_byte, [15:8] major_version,
                                    // [23:16] revision, [31:24] tag_flags,
                                    // [59:32] tag_size, [63:60] zero
   output logic [2:0]  rsp_tuser,   // [1:0] report_kind, [2] byte_present
   output logic        rsp_tlast    // last_of_tag
);

   logic             byte_fire;
   logic             res_valid;
   result_type       res;
   result_type       head;
   queue_status_type q_status;
   logic             pop;

   assign req_tready = !q_status.full;
   assign byte_fire  = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   id3_front u_front (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (byte_fire),
      .data_byte (req_tdata),
      .res_valid (res_valid),
      .res       (res)
   );

   id3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (byte_fire && res_valid),
      .push_data  (res),
      .pop        (pop),
      .head_valid (rsp_tvalid),
      .head_data  (head),
      .status     (q_status)
   );

   assign rsp_tdata = {4'b0000, head.tag_size, head.tag_flags, head.revision,
                       head.major_version, head.body_byte};
   assign rsp_tuser = {head.byte_present, head.report_kind};
   assign rsp_tlast = head.last_of_tag;

   // queue occupancy never exceeds its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QUEUE_DEPTH)
      else $error("result queue overflow");

   // header reports carry neither a body byte nor the end mark
   a_report_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] != KIND_BODY) |-> !rsp_tuser[2] && !rsp_tlast)
      else $error("header report carries body marks");

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

// ===== bench/tb_id3v2_header_and_unsync_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_id3v2_header_and_unsync_filter
// Self-checking bench for the tag header parser and unsync filter: a short
// table of hand-made tags, then about a thousand bytes of random tags with
// random idling on both sides; the table is checked against its hand-typed
// results, the random tags against a byte-level model of the parser kept in the bench.
// ----------------------------------------------------------------------------
module tb_id3v2_header_and_unsync_filter
   import id3_pkg::*;
();

   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_WAIT  = 10;

   typedef struct packed {
      logic [7:0] raw;
      logic       has_fixed;   // row carries a hand-typed result
      result_type fixed;
   } tag_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;           // [7:0] body_byte, [15:8] major_version,
                                     // [23:16] revision, [31:24] tag_flags,
                                     // [59:32] tag_size, [63:60] zero
   logic [2:0]  rsp_tuser;           // [1:0] report_kind, [2] byte_present
   logic        rsp_tlast;           // last_of_tag

   tag_byte_type tag_stream [$];
   result_type   reports_due [$];
   int           mismatches = 0;
   int           idle_cycles = 0;

   // parser model state
   logic [HDR_IDX_W-1:0] hdr_pos = '0;
   logic                 mark_seen_ok = 1'b1;
   logic [7:0]           hdr_major = '0;
   logic [7:0]           hdr_rev = '0;
   logic [7:0]           hdr_flags = '0;
   logic [SIZE_W-1:0]    size_sum = '0;
   logic [SIZE_W-1:0]    body_remaining = '0;
   logic                 in_tag_body = 1'b0;
   logic                 unsync_strip = 1'b0;
   logic                 last_raw_ff = 1'b0;

   id3v2_header_and_unsync_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void restart_header();
      hdr_pos      = '0;
      mark_seen_ok = 1'b1;
      hdr_major    = '0;
      hdr_rev      = '0;
      hdr_flags    = '0;
      size_sum     = '0;
   endfunction

   // advances the parser model by one raw byte; returns 1 when a result is due
   function automatic bit predict_tag_byte(input logic [7:0] b, output result_type rep);
      bit drop;
      bit ok;
      rep = '0;
      if (in_tag_body) begin
         drop = unsync_strip && last_raw_ff && (b == BYTE_ZERO);
         last_raw_ff = (b == BYTE_FF);
         rep.report_kind  = KIND_BODY;
         rep.body_byte    = drop ? BYTE_ZERO : b;
         rep.byte_present = !drop;
         body_remaining   = body_remaining - 1'b1;
         if (body_remaining == '0) begin
            rep.last_of_tag = 1'b1;
            in_tag_body     = 1'b0;
            unsync_strip    = 1'b0;
            last_raw_ff     = 1'b0;
            restart_header();
         end
         return 1'b1;
      end
      case (hdr_pos)
         HDR_IDX_MARK0: if (b != MARK_CHAR0) mark_seen_ok = 1'b0;
         HDR_IDX_MARK1: if (b != MARK_CHAR1) mark_seen_ok = 1'b0;
         HDR_IDX_MARK2: if (b != MARK_CHAR2) mark_seen_ok = 1'b0;
         HDR_IDX_MAJOR: hdr_major = b;
         HDR_IDX_REV:   hdr_rev = b;
         HDR_IDX_FLAGS: hdr_flags = b;
         // sync-safe size: top bit of each byte is dropped
         default:       size_sum = {size_sum[SIZE_W-8:0], b[6:0]};
      endcase
      if (hdr_pos < HDR_IDX_LAST) begin
         hdr_pos = hdr_pos + 1'b1;
         return 1'b0;
      end
      ok = mark_seen_ok && (size_sum != '0) &&
           (hdr_major >= MAJOR_MIN) && (hdr_major <= MAJOR_MAX);
      rep.report_kind   = ok ? KIND_ACCEPT : KIND_REJECT;
      rep.major_version = hdr_major;
      rep.revision      = hdr_rev;
      rep.tag_flags     = hdr_flags;
      rep.tag_size      = size_sum;
      if (ok) begin
         in_tag_body    = 1'b1;
         body_remaining = size_sum;
         unsync_strip   = (hdr_major == MAJOR_UNSYNC) && hdr_flags[UNSYNC_BIT];
         last_raw_ff    = 1'b0;
      end
      restart_header();
      return 1'b1;
   endfunction

   function automatic result_type fixed_report(
      input kind_type kind, input logic [7:0] body, input logic present,
      input logic last, input logic [7:0] major, input logic [7:0] rev,
      input logic [7:0] flags, input logic [SIZE_W-1:0] size);
      result_type r;
      r.report_kind   = kind;
      r.body_byte     = body;
      r.byte_present  = present;
      r.last_of_tag   = last;
      r.major_version = major;
      r.revision      = rev;
      r.tag_flags     = flags;
      r.tag_size      = size;
      return r;
   endfunction

   function automatic void push_raw(input logic [7:0] b);
      tag_stream.push_back(tag_byte_type'{b, 1'b0, '0});
   endfunction

   // mostly well-formed tags with random content, the rest broken headers
   function automatic void append_random_tag();
      logic [7:0]        hdr [10];
      logic [SIZE_W-1:0] sz;
      int unsigned       pick;
      int unsigned       k;
      int unsigned       r;
      bit                good;
      pick   = $urandom_range(0, 99);
      hdr[0] = MARK_CHAR0;
      hdr[1] = MARK_CHAR1;
      hdr[2] = MARK_CHAR2;
      hdr[3] = 8'($urandom_range(MAJOR_MIN, MAJOR_MAX));
      hdr[4] = 8'($urandom);
      hdr[5] = 8'($urandom);
      if (pick < 30) begin
         hdr[3] = MAJOR_UNSYNC;
         hdr[5][UNSYNC_BIT] = 1'b1;
      end
      sz   = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom_range(25, 300))
                                         : SIZE_W'($urandom_range(1, 24));
      good = 1'b1;
      if (pick >= 78) begin
         good = 1'b0;
         sz   = SIZE_W'($urandom);
         case (pick % 4)
            0: begin
               k = $urandom_range(0, 2);
               hdr[k] = hdr[k] ^ 8'($urandom_range(1, 255));
            end
            1: begin
               do hdr[3] = 8'($urandom); while (hdr[3] >= MAJOR_MIN && hdr[3] <= MAJOR_MAX);
            end
            2: sz = '0;
            default: begin
               for (k = 0; k < 6; k++) hdr[k] = 8'($urandom);
               if (hdr[0] == MARK_CHAR0) hdr[0] = ~hdr[0];
            end
         endcase
      end
      for (k = 0; k < 4; k++) begin
         hdr[6+k] = {1'($urandom_range(0, 1)), sz[SIZE_W-1-7*k -: 7]};
      end
      for (k = 0; k < 10; k++) push_raw(hdr[k]);
      if (good) begin
         for (k = 0; k < sz; k++) begin
            r = $urandom_range(0, 9);
            push_raw(r < 3 ? BYTE_FF : (r < 6 ? BYTE_ZERO : 8'($urandom)));
         end
      end
   endfunction

   task automatic check_report(input result_type got);
      result_type want;
      if (reports_due.size() == 0) begin
         $error("result with nothing expected: kind %0d byte %h", got.report_kind,
                got.body_byte);
         mismatches++;
         return;
      end
      want = reports_due.pop_front();
      if (got.report_kind !== want.report_kind) begin
         $error("report_kind: expected %0d, got %0d", want.report_kind, got.report_kind);
         mismatches++;
      end
      if (got.body_byte !== want.body_byte) begin
         $error("body_byte: expected %h, got %h", want.body_byte, got.body_byte);
         mismatches++;
      end
      if (got.byte_present !== want.byte_present) begin
         $error("byte_present: expected %b, got %b", want.byte_present, got.byte_present);
         mismatches++;
      end
      if (got.last_of_tag !== want.last_of_tag) begin
         $error("last_of_tag: expected %b, got %b", want.last_of_tag, got.last_of_tag);
         mismatches++;
      end
      if (got.major_version !== want.major_version) begin
         $error("major_version: expected %h, got %h", want.major_version, got.major_version);
         mismatches++;
      end
      if (got.revision !== want.revision) begin
         $error("revision: expected %h, got %h", want.revision, got.revision);
         mismatches++;
      end
      if (got.tag_flags !== want.tag_flags) begin
         $error("tag_flags: expected %h, got %h", want.tag_flags, got.tag_flags);
         mismatches++;
      end
      if (got.tag_size !== want.tag_size) begin
         $error("tag_size: expected %h, got %h", want.tag_size, got.tag_size);
         mismatches++;
      end
   endtask

   // sender: walks the byte stream, model runs on each accepted transfer
   initial begin
      tag_byte_type item;
      result_type   rep;
      bit           produced;
      int unsigned  gap;
      int unsigned  sent;

      // v3 unsync tag, size bytes with top bits set, three body bytes
      tag_stream.push_back(tag_byte_type'{MARK_CHAR0, 1'b0, '0});
      tag_stream.push_back(tag_byte_type'{MARK_CHAR1, 1'b0, '0});
      tag_stream.push_back(tag_byte_type'{MARK_CHAR2, 1'b0, '0});
      tag_stream.push_back(tag_byte_type'{MAJOR_UNSYNC, 1'b0, '0});
      tag_stream.push_back(tag_byte_type'{8'hFF, 1'b0, '0});
      tag_stream.push_back(tag_byte_type'{8'h80, 1'b0, '0});
      tag_stream.push_back(tag_byte_type'{8'h80, 1'b0, '0});
      tag_stream.push_back(tag_byte_type'{8'h80, 1'b0, '0});
      tag_stream.push_back(tag_byte_type'{8'h80, 1'b0, '0});
      tag_stream.push_back(tag_byte_type'{8'h83, 1'b1,
         fixed_report(KIND_ACCEPT, 8'h00, 1'b0, 1'b0, 8'h03, 8'hFF, 8'h80, 28'd3)});
      // first body byte is kept even though it is zero
      tag_stream.push_back(tag_byte_type'{8'h00, 1'b1,
         fixed_report(KIND_BODY, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 28'd0)});
      tag_stream.push_back(tag_byte_type'{8'hFF, 1'b1,
         fixed_report(KIND_BODY, 8'hFF, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 28'd0)});
      // zero after 0xff is removed, still marked as end of tag
      tag_stream.push_back(tag_byte_type'{8'h00, 1'b1,
         fixed_report(KIND_BODY, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 28'd0)});
      // all-ones header: bad mark and version, report carries raw values
      repeat (6) tag_stream.push_back(tag_byte_type'{8'hFF, 1'b0, '0});
      repeat (3) tag_stream.push_back(tag_byte_type'{8'h7F, 1'b0, '0});
      tag_stream.push_back(tag_byte_type'{8'h7F, 1'b1,
         fixed_report(KIND_REJECT, 8'h00, 1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 28'hFFFFFFF)});

      while (tag_stream.size() < 1000) append_random_tag();

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      for (sent = 0; sent < tag_stream.size(); sent++) begin
         item = tag_stream[sent];
         gap  = ((sent / 128) % 3 == 1) ? 0 : $urandom_range(0, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= item.raw;
         do @(posedge clock); while (!req_tready);
         produced = predict_tag_byte(item.raw, rep);
         if (item.has_fixed) reports_due.push_back(item.fixed);
         else if (produced) reports_due.push_back(rep);
         @(negedge clock);
      end
      req_tvalid <= 1'b0;

      while (reports_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // receiver: random stalls, one long hold-off to back the block up
   initial begin
      result_type  got;
      int unsigned stall;
      int unsigned taken;
      taken = 0;
      wait (!reset);
      forever begin
         if (taken == 60) stall = HOLD_CYCLES;
         else if ((taken / 100) % 3 == 2) stall = 0;
         else stall = $urandom_range(0, 8);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.report_kind   = kind_type'(rsp_tuser[1:0]);
         got.byte_present  = rsp_tuser[2];
         got.body_byte     = rsp_tdata[7:0];
         got.major_version = rsp_tdata[15:8];
         got.revision      = rsp_tdata[23:16];
         got.tag_flags     = rsp_tdata[31:24];
         got.tag_size      = rsp_tdata[59:32];
         got.last_of_tag   = rsp_tlast;
         check_report(got);
         taken++;
         @(negedge clock);
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

endmodule

// ===== files.f =====
rtl/id3_pkg.sv
rtl/id3_front.sv
rtl/id3_queue.sv
rtl/id3v2_header_and_unsync_filter.sv
bench/tb_id3v2_header_and_unsync_filter.sv
